>>> rtl/core/rgbhsl_pkg.sv
// rgbhsl_pkg: shared widths, payload types and the divider step function
// for the rgb to hsl pixel converter; depends on nothing
`timescale 1ns / 1ps

package rgbhsl_pkg;

    localparam int CH_W    = 8;   // one color channel
    localparam int HUE_W   = 11;  // hue numerator and 6*d denominator
    localparam int SAT_W   = 8;   // saturation numerator and denominator
    localparam int FIELD_W = 16;  // hue and saturation result fields

    typedef logic [CH_W-1:0]    chan_t;
    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [SAT_W-1:0]   sat_t;
    typedef logic [FIELD_W-1:0] frac_t;

    // operands handed to the divider pipe
    typedef struct packed {
        hue_t hue_num;
        hue_t hue_den;
        sat_t sat_num;
        sat_t sat_den;
    } div_in_t;

    // side data that rides along with the division
    typedef struct packed {
        logic  gray;
        chan_t light;
        logic  last;
    } tag_t;

    typedef struct packed {
        logic qbit;
        hue_t rem;
    } step_t;

    // one restoring step: optional shift, compare, subtract
    function automatic step_t div_step(hue_t rem, hue_t den, logic shift);
        logic [HUE_W:0] t;
        logic [HUE_W:0] dx;
        step_t          res;
        t        = shift ? {rem, 1'b0} : {1'b0, rem};
        dx       = {1'b0, den};
        res.qbit = (t >= dx);
        if (res.qbit)
        begin
            t = t - dx;
        end
        res.rem = t[HUE_W-1:0];
        return res;
    endfunction

endpackage

>>> rtl/core/rgbhsl_if.sv
// rgbhsl_pix_if and rgbhsl_hsl_if: valid/ready channels for the pixel
// input and the hsl result; depends on nothing
`timescale 1ns / 1ps

interface rgbhsl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_pixel, output ready);
endinterface

interface rgbhsl_hsl_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [7:0]  lightness;
    logic        last_out;

    modport source (output valid, output hue, output saturation,
                    output lightness, output last_out, input ready);
    modport sink   (input valid, input hue, input saturation,
                    input lightness, input last_out, output ready);
endinterface

>>> rtl/core/rgb_to_hsl_pixel.sv
// rgb_to_hsl_pixel: top level of the rgb to hsl pixel converter
// depends on rgbhsl_pkg, rgbhsl_if and rgbhsl_div_pipe
`timescale 1ns / 1ps

// usage
// - pixel: valid/ready sink, one rgb word (8-bit red, green, blue and a
//   last-pixel mark) per handshake
// - hsl: valid/ready source, one word per pixel with 16-bit hue and
//   saturation fractions, 8-bit lightness and the copied last mark
// - throughput: one pixel per clock, sustained, when hsl.ready stays high
// - pipeline: three front stages find max/min and build the operands,
//   then FRAC_BITS + 1 divider stages each resolve one quotient bit of
//   hue and saturation side by side, then one output register
// - every stage carries a valid bit and loads when it is empty or its
//   successor moves, so bubbles collapse and a stall loses nothing
// - when the receiver stalls the output word holds, the pipe keeps
//   filling, and pixel.ready drops only once every stage is full
// - reset clears all valid bits; no word is in flight afterwards
// - gray pixels give hue and saturation zero; full saturation reads 65535

module rgb_to_hsl_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rgbhsl_pix_if.sink           pixel,
    rgbhsl_hsl_if.source         hsl
);

    localparam int STEPS  = FRAC_BITS + 1;     // integer bit plus fraction bits
    localparam int FRONT  = 3;                 // input, max/min, operand stages
    localparam int NS     = FRONT + STEPS + 1; // plus the output register
    localparam logic [8:0] SUM_LIMIT = 9'd255;
    localparam logic [9:0] SUM_FULL  = 10'd510;

    // stage valid bits and load enables
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = hsl.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = pixel.valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign pixel.ready = en[0];

    // stage a: register the incoming word
    rgbhsl_pkg::chan_t r_a_reg, g_a_reg, b_a_reg;
    logic              last_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_a_reg    <= pixel.red;
            g_a_reg    <= pixel.green;
            b_a_reg    <= pixel.blue;
            last_a_reg <= pixel.last_pixel;
        end
    end

    // stage b: largest and smallest channel, which formula applies
    rgbhsl_pkg::chan_t mx_w, mn_w;
    rgbhsl_pkg::chan_t r_b_reg, g_b_reg, b_b_reg, mx_b_reg, mn_b_reg;
    logic              r_max_b_reg, g_max_b_reg, last_b_reg;

    always_comb
    begin
        mx_w = r_a_reg;
        mn_w = r_a_reg;
        if (g_a_reg > mx_w) mx_w = g_a_reg;
        if (b_a_reg > mx_w) mx_w = b_a_reg;
        if (g_a_reg < mn_w) mn_w = g_a_reg;
        if (b_a_reg < mn_w) mn_w = b_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            r_b_reg     <= r_a_reg;
            g_b_reg     <= g_a_reg;
            b_b_reg     <= b_a_reg;
            mx_b_reg    <= mx_w;
            mn_b_reg    <= mn_w;
            r_max_b_reg <= (r_a_reg == mx_w);
            g_max_b_reg <= (g_a_reg == mx_w);
            last_b_reg  <= last_a_reg;
        end
    end

    // stage c: divider operands; hue numerator kept non-negative over 6d
    rgbhsl_pkg::chan_t   d_w;
    logic [8:0]          s_w;
    rgbhsl_pkg::hue_t    d_ext, d6_w, hue_num_w;
    logic [9:0]          s_rev_w;
    rgbhsl_pkg::div_in_t div_in_reg;
    rgbhsl_pkg::tag_t    tag_c_reg;

    always_comb
    begin
        d_w     = mx_b_reg - mn_b_reg;
        s_w     = {1'b0, mx_b_reg} + {1'b0, mn_b_reg};
        s_rev_w = SUM_FULL - {1'b0, s_w};
        d_ext   = rgbhsl_pkg::hue_t'(d_w);
        d6_w    = (d_ext << 2) + (d_ext << 1);
        if (r_max_b_reg)
        begin
            if (g_b_reg >= b_b_reg)
                hue_num_w = rgbhsl_pkg::hue_t'(g_b_reg - b_b_reg);
            else
                hue_num_w = d6_w - rgbhsl_pkg::hue_t'(b_b_reg - g_b_reg);
        end
        else if (g_max_b_reg)
        begin
            hue_num_w = (d_ext << 1) + rgbhsl_pkg::hue_t'(b_b_reg)
                      - rgbhsl_pkg::hue_t'(r_b_reg);
        end
        else
        begin
            hue_num_w = (d_ext << 2) + rgbhsl_pkg::hue_t'(r_b_reg)
                      - rgbhsl_pkg::hue_t'(g_b_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            div_in_reg.hue_num <= hue_num_w;
            div_in_reg.hue_den <= d6_w;
            div_in_reg.sat_num <= d_w;
            div_in_reg.sat_den <= (s_w < SUM_LIMIT) ? s_w[7:0] : s_rev_w[7:0];
            tag_c_reg.gray     <= (d_w == '0);
            tag_c_reg.light    <= s_w[8:1];
            tag_c_reg.last     <= last_b_reg;
        end
    end

    // divider stages
    logic [STEPS-1:0] hue_q, sat_q;
    rgbhsl_pkg::tag_t tag_out;

    rgbhsl_div_pipe #(
        .STEPS (STEPS)
    ) u_div (
        .clk     (clk),
        .en      (en[FRONT +: STEPS]),
        .din     (div_in_reg),
        .tag_in  (tag_c_reg),
        .hue_q   (hue_q),
        .sat_q   (sat_q),
        .tag_out (tag_out)
    );

    // output register: clamp a saturation of one, zero gray pixels
    logic [FRAC_BITS-1:0] hue_frac, sat_frac;
    rgbhsl_pkg::frac_t    hue_reg, sat_reg;
    rgbhsl_pkg::chan_t    light_reg;
    logic                 last_reg;

    assign hue_frac = hue_q[FRAC_BITS-1:0];
    assign sat_frac = sat_q[FRAC_BITS] ? '1 : sat_q[FRAC_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            hue_reg   <= tag_out.gray ? '0 : rgbhsl_pkg::frac_t'(hue_frac);
            sat_reg   <= tag_out.gray ? '0 : rgbhsl_pkg::frac_t'(sat_frac);
            light_reg <= tag_out.light;
            last_reg  <= tag_out.last;
        end
    end

    assign hsl.valid      = v_reg[NS-1];
    assign hsl.hue        = hue_reg;
    assign hsl.saturation = sat_reg;
    assign hsl.lightness  = light_reg;
    assign hsl.last_out   = last_reg;

`ifndef SYNTHESIS
    // input backpressure only when every stage holds a word
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (&v_reg))
        else $error("pixel.ready low with an empty stage");

    // hue stays below one full turn, so its integer bit never sets
    a_hue_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-2] && !tag_out.gray) |-> !hue_q[FRAC_BITS])
        else $error("hue quotient reached one turn");

    // a stalled output stage keeps its valid bit into the next cycle
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-1] && !hsl.ready) |=> v_reg[NS-1])
        else $error("output word dropped while stalled");
`endif

endmodule

>>> rtl/core/rgbhsl_div_pipe.sv
// rgbhsl_div_pipe: two lane pipelined restoring divider, one quotient bit
// per stage, for hue and saturation; depends on rgbhsl_pkg
`timescale 1ns / 1ps

module rgbhsl_div_pipe #(
    parameter int STEPS = 17
) (
    input  logic                 clk,
    input  logic [STEPS-1:0]     en,
    input  rgbhsl_pkg::div_in_t  din,
    input  rgbhsl_pkg::tag_t     tag_in,
    output logic [STEPS-1:0]     hue_q,
    output logic [STEPS-1:0]     sat_q,
    output rgbhsl_pkg::tag_t     tag_out
);

    rgbhsl_pkg::hue_t h_rem_reg [STEPS];
    rgbhsl_pkg::hue_t h_den_reg [STEPS];
    logic [STEPS-1:0] h_q_reg   [STEPS];
    rgbhsl_pkg::sat_t s_rem_reg [STEPS];
    rgbhsl_pkg::sat_t s_den_reg [STEPS];
    logic [STEPS-1:0] s_q_reg   [STEPS];
    rgbhsl_pkg::tag_t tag_reg   [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        rgbhsl_pkg::hue_t    h_rem_in;
        rgbhsl_pkg::hue_t    h_den_in;
        logic [STEPS-1:0]    h_q_in;
        rgbhsl_pkg::sat_t    s_rem_in;
        rgbhsl_pkg::sat_t    s_den_in;
        logic [STEPS-1:0]    s_q_in;
        rgbhsl_pkg::tag_t    tag_in_w;
        rgbhsl_pkg::step_t   h_st;
        rgbhsl_pkg::step_t   s_st;
        logic                shift;

        if (i == 0)
        begin : g_first
            assign h_rem_in = din.hue_num;
            assign h_den_in = din.hue_den;
            assign h_q_in   = '0;
            assign s_rem_in = din.sat_num;
            assign s_den_in = din.sat_den;
            assign s_q_in   = '0;
            assign tag_in_w = tag_in;
            assign shift    = 1'b0;  // integer bit, no shift
        end
        else
        begin : g_next
            assign h_rem_in = h_rem_reg[i-1];
            assign h_den_in = h_den_reg[i-1];
            assign h_q_in   = h_q_reg[i-1];
            assign s_rem_in = s_rem_reg[i-1];
            assign s_den_in = s_den_reg[i-1];
            assign s_q_in   = s_q_reg[i-1];
            assign tag_in_w = tag_reg[i-1];
            assign shift    = 1'b1;
        end

        assign h_st = rgbhsl_pkg::div_step(h_rem_in, h_den_in, shift);
        assign s_st = rgbhsl_pkg::div_step(rgbhsl_pkg::hue_t'(s_rem_in),
                                           rgbhsl_pkg::hue_t'(s_den_in), shift);

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                h_rem_reg[i] <= h_st.rem;
                h_den_reg[i] <= h_den_in;
                h_q_reg[i]   <= {h_q_in[STEPS-2:0], h_st.qbit};
                s_rem_reg[i] <= s_st.rem[rgbhsl_pkg::SAT_W-1:0];
                s_den_reg[i] <= s_den_in;
                s_q_reg[i]   <= {s_q_in[STEPS-2:0], s_st.qbit};
                tag_reg[i]   <= tag_in_w;
            end
        end
    end

    assign hue_q   = h_q_reg[STEPS-1];
    assign sat_q   = s_q_reg[STEPS-1];
    assign tag_out = tag_reg[STEPS-1];

endmodule
